// File: hdl/ldf_pkg.sv
// Package for the CR/LF line deframer: result kinds, byte codes and queue sizing.
// Shared by every module of the block and by its port checker; depends on nothing.
package ldf_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam int LEN_W  = 16;
    localparam int PEND_W = 20;
    localparam int CFG_W  = 20;

    localparam logic CFG_MAX_LINE_LENGTH   = 1'b0;
    localparam logic CFG_MAX_PENDING_BYTES = 1'b1;

    localparam logic [LEN_W-1:0]  MAX_LINE_LENGTH_RST   = 16'd4096;
    localparam logic [PEND_W-1:0] MAX_PENDING_BYTES_RST = 20'd65536;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Results caused by one input byte: one or two of them.
    typedef struct packed {
        logic [1:0] kind0;
        logic [7:0] byte0;
        logic       has1;
        logic [7:0] byte1;
    } ldf_entry_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } ldf_qstat_t;

endpackage

// File: hdl/line_deframer_crlf.sv
// Top level of the CR/LF line deframer: front classifier, result queue and output stage.
// Depends on ldf_pkg, ldf_front, ldf_queue and ldf_back.
//
// Usage: each request on the input channel carries one received byte. The block splits
// the stream into lines at LF, drops a CR that directly precedes an LF, skips empty
// lines and keeps at most max_line_length content bytes per line. Each line is sent as
// data requests followed by one end-of-line request. More than max_pending_bytes bytes
// since the last LF produce a single overflow error request, after which all input is
// accepted and ignored until reset. out_last marks the final result caused by a byte.
// Throughput: one input byte per cycle. A byte that releases a held CR yields two
// results, which leave the output one after the other; the four-entry queue between the front and
// the output register absorbs these, and in_stall rises only when that queue is full.
// An accepted byte's entry is written into the queue, and its result then loads the output register.
// The output register lets the next byte be accepted while a result is still waiting.
// When the receiver holds out_stall, the output request holds steady, the queue fills
// and then in_stall is raised. Reset clears the line state, the queue and the output
// register and restores both configuration registers to their defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge.
module line_deframer_crlf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ldf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                out_kind,
    output logic [7:0]                out_byte,
    output logic                      out_last
);
    import ldf_pkg::*;

    ldf_qstat_t qstat;
    ldf_entry_t push_entry;
    ldf_entry_t head;
    logic       push;
    logic       pop;

    // The front updates line state on every accepted byte and pushes an entry
    // only when the byte causes at least one result.
    ldf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    ldf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // The back part emits one result per cycle unless out_stall holds it, and pops an entry after its last result.
    ldf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// File: hdl/ldf_front.sv
// Front part of the deframer: takes bytes, tracks line state and builds queue entries.
// Depends on ldf_pkg.
module ldf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ldf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    input  ldf_pkg::ldf_qstat_t       qstat,
    output logic                      push,
    output ldf_pkg::ldf_entry_t       push_entry
);
    import ldf_pkg::*;

    logic [LEN_W-1:0]  max_len_reg;
    logic [PEND_W-1:0] max_pend_reg;
    logic              closed_reg, closed_next;
    logic              cr_reg, cr_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic              accept;
    logic [PEND_W:0]   pend_inc;
    logic              ovf;
    logic              is_lf, is_cr;
    logic [LEN_W-1:0]  cnt1, cnt2;
    logic              keep0, keep1;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full && !closed_reg;

    assign pend_inc = {1'b0, pend_reg} + {{PEND_W{1'b0}}, 1'b1};
    assign ovf      = pend_inc > {1'b0, max_pend_reg};
    assign is_lf    = in_byte == BYTE_LF;
    assign is_cr    = in_byte == BYTE_CR;

    // Saturating content counts after one and after two more content bytes.
    assign cnt1  = (cnt_reg == {LEN_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt2  = (cnt1 == {LEN_W{1'b1}}) ? cnt1 : cnt1 + 1'b1;
    assign keep0 = cnt_reg < max_len_reg;
    assign keep1 = cnt1 < max_len_reg;

    always_comb
    begin
        closed_next = closed_reg;
        cr_next     = cr_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        push        = 1'b0;
        push_entry  = '{kind0: KIND_DATA, byte0: in_byte, has1: 1'b0, byte1: in_byte};
        if (accept)
        begin
            if (ovf)
            begin
                push             = 1'b1;
                push_entry.kind0 = KIND_ERR;
                push_entry.byte0 = 8'd0;
                closed_next      = 1'b1;
                cr_next          = 1'b0;
            end
            else if (is_lf)
            begin
                push             = cnt_reg != '0;
                push_entry.kind0 = KIND_EOL;
                push_entry.byte0 = 8'd0;
                cr_next          = 1'b0;
                cnt_next         = '0;
                pend_next        = '0;
            end
            else if (is_cr)
            begin
                pend_next = pend_inc[PEND_W-1:0];
                cr_next   = 1'b1;
                if (cr_reg)
                begin
                    // The earlier CR turns out to be content.
                    push     = keep0;
                    cnt_next = cnt1;
                end
            end
            else
            begin
                pend_next = pend_inc[PEND_W-1:0];
                cr_next   = 1'b0;
                if (cr_reg)
                begin
                    push     = keep0 || keep1;
                    cnt_next = cnt2;
                    if (keep0)
                    begin
                        push_entry.byte0 = BYTE_CR;
                        push_entry.has1  = keep1;
                    end
                end
                else
                begin
                    push     = keep0;
                    cnt_next = cnt1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= MAX_LINE_LENGTH_RST;
            max_pend_reg <= MAX_PENDING_BYTES_RST;
            closed_reg   <= 1'b0;
            cr_reg       <= 1'b0;
            cnt_reg      <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MAX_LINE_LENGTH)
                max_len_reg <= cfg_data[LEN_W-1:0];
            if (cfg_we && cfg_index == CFG_MAX_PENDING_BYTES)
                max_pend_reg <= cfg_data[PEND_W-1:0];
            closed_reg <= closed_next;
            cr_reg     <= cr_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// File: hdl/ldf_queue.sv
// Short queue of result entries between the front and back parts of the deframer.
// Depends on ldf_pkg.
module ldf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ldf_pkg::ldf_entry_t push_entry,
    input  logic                pop,
    output ldf_pkg::ldf_entry_t head,
    output ldf_pkg::ldf_qstat_t qstat
);
    import ldf_pkg::*;

    ldf_entry_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qstat.full  = cnt_reg == QCNT_W'(QDEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hdl/ldf_back.sv
// Back part of the deframer: unpacks queue entries into single results in the output register.
// Depends on ldf_pkg.
module ldf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ldf_pkg::ldf_entry_t head,
    input  ldf_pkg::ldf_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import ldf_pkg::*;

    logic       valid_reg, valid_next;
    logic       sub_reg, sub_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load, take;

    assign load = !valid_reg || !out_stall;
    assign take = load && !qstat.empty;

    always_comb
    begin
        valid_next = load ? !qstat.empty : valid_reg;
        sub_next   = sub_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (take)
        begin
            if (!sub_reg)
            begin
                kind_next = head.kind0;
                byte_next = head.byte0;
                last_next = !head.has1;
                pop       = !head.has1;
                sub_next  = head.has1;
            end
            else
            begin
                kind_next = KIND_DATA;
                byte_next = head.byte1;
                last_next = 1'b1;
                pop       = 1'b1;
                sub_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

// File: hdl/ldf_checker.sv
// Port checker for the CR/LF line deframer, bound to the top level.
// Depends on ldf_pkg and line_deframer_crlf.
module ldf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic       out_last
);
    import ldf_pkg::*;

    // A stalled result request stays in place unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
            && $stable(out_last))
        else $error("stalled output request changed");

    // Only the three defined kinds ever leave the block.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind == KIND_DATA || out_kind == KIND_EOL || out_kind == KIND_ERR)
        else $error("undefined result kind");

    // End-of-line and error results carry no byte and always end their input's results.
    a_ctrl_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0 && out_last)
        else $error("control result with byte or without last mark");

    // Once the overflow error is delivered the block is closed and has nothing more.
    a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_kind == KIND_ERR |=> !out_valid)
        else $error("result after overflow error");

    // After the error nothing new can appear, so a following idle output stays idle.
    a_closed_stays: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && !out_stall && out_kind == KIND_ERR) && !out_valid |=> !out_valid)
        else $error("block reopened after overflow error");

endmodule

bind line_deframer_crlf ldf_checker u_ldf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
);

// File: sim/line_deframer_crlf_test.sv
// Self-checking testbench for line_deframer_crlf: random line traffic with CR/LF framing.
// It predicts every result in a small line tracker class and checks each one as it leaves.
// Depends on ldf_pkg and the line_deframer_crlf RTL only.

typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
} line_result_t;

// Tracks the line state of the block and keeps the results still owed to the receiver.
class crlf_line_tracker;
    logic [15:0]  cap_line;
    logic [19:0]  cap_pending;
    bit           is_closed;
    bit           holding_cr;
    logic [15:0]  line_bytes;
    logic [19:0]  bytes_since_lf;
    line_result_t due_results[$];
    line_result_t step_out[2];
    int           step_n;
    int           errors;

    function new();
        cap_line       = ldf_pkg::MAX_LINE_LENGTH_RST;
        cap_pending    = ldf_pkg::MAX_PENDING_BYTES_RST;
        is_closed      = 0;
        holding_cr     = 0;
        line_bytes     = '0;
        bytes_since_lf = '0;
        step_n         = 0;
        errors         = 0;
    endfunction

    function void set_reg(logic index, logic [19:0] value);
        if (index == ldf_pkg::CFG_MAX_LINE_LENGTH)
            cap_line = value[15:0];
        else
            cap_pending = value;
    endfunction

    function int outstanding();
        return due_results.size();
    endfunction

    // Appends one predicted result at the tail of the owed list.
    function void owe_result(line_result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // True when a non-LF byte now would leave no room for the LF that must follow it.
    function bit must_break();
        return !is_closed && ({1'b0, bytes_since_lf} + 21'd2 > {1'b0, cap_pending});
    endfunction

    // A content byte counts toward the line even when it is past the length cap.
    function void keep_content(logic [7:0] b);
        if (line_bytes < cap_line)
        begin
            step_out[step_n].kind = ldf_pkg::KIND_DATA;
            step_out[step_n].data = b;
            step_out[step_n].last = 1'b0;
            step_n++;
        end
        if (line_bytes != 16'hFFFF)
            line_bytes++;
    endfunction

    function void take_byte(logic [7:0] b);
        logic [20:0]  count;
        line_result_t r;
        if (is_closed)
            return;
        step_n = 0;
        count  = {1'b0, bytes_since_lf} + 21'd1;
        if (count > {1'b0, cap_pending})
        begin
            // Overflow wins over everything else the byte would have done.
            r.kind = ldf_pkg::KIND_ERR;
            r.data = 8'd0;
            r.last = 1'b1;
            owe_result(r);
            is_closed  = 1;
            holding_cr = 0;
            return;
        end
        bytes_since_lf = count[19:0];
        if (b == ldf_pkg::BYTE_LF)
        begin
            if (line_bytes != 0)
            begin
                step_out[0].kind = ldf_pkg::KIND_EOL;
                step_out[0].data = 8'd0;
                step_out[0].last = 1'b0;
                step_n = 1;
            end
            holding_cr     = 0;
            line_bytes     = '0;
            bytes_since_lf = '0;
        end
        else if (b == ldf_pkg::BYTE_CR)
        begin
            if (holding_cr)
                keep_content(ldf_pkg::BYTE_CR);
            holding_cr = 1;
        end
        else
        begin
            if (holding_cr)
                keep_content(ldf_pkg::BYTE_CR);
            holding_cr = 0;
            keep_content(b);
        end
        for (int k = 0; k < step_n; k++)
        begin
            r = step_out[k];
            r.last = (k == step_n - 1);
            owe_result(r);
        end
    endfunction

    function void match_result(logic [1:0] kind, logic [7:0] data, logic last);
        line_result_t want;
        if (due_results.size() == 0)
        begin
            $error("unexpected result: out_kind %0d out_byte 'h%02h out_last %0b",
                   kind, data, last);
            errors++;
            return;
        end
        want = due_results[0];
        due_results.delete(0);
        if (kind !== want.kind)
        begin
            $error("out_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
        end
        if (data !== want.data)
        begin
            $error("out_byte: expected 'h%02h, actual 'h%02h", want.data, data);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("out_last: expected %0b, actual %0b", want.last, last);
            errors++;
        end
    endfunction
endclass

module line_deframer_crlf_test;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic                      cfg_index = ldf_pkg::CFG_MAX_LINE_LENGTH;
    logic [ldf_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [7:0]                in_byte   = 8'd0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                out_kind;
    logic [7:0]                out_byte;
    logic                      out_last;

    crlf_line_tracker tracker;

    // When calm is set neither side idles, so the block runs at full rate.
    bit calm        = 0;
    int bytes_sent  = 0;
    // The sender asks for a long receiver hold-off by bumping hold_asked; the receiver
    // process counts the stretch down on its own.
    int hold_asked  = 0;
    int hold_done   = 0;
    int hold_left   = 0;

    // Line limits for the random phases, a mix of the largest settings and very tight ones.
    // A pending limit of one only lets bare LFs through, which the guard in send_byte forces.
    logic [15:0] phase_len  [7] = '{16'd65535, 16'd1, 16'd0, 16'd3, 16'd16, 16'd4096, 16'd200};
    logic [19:0] phase_pend [7] = '{20'd1048575, 20'd1048575, 20'd40, 20'd1, 20'd12,
                                    20'd1048575, 20'd64};

    line_deframer_crlf dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when the sender asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_asked)
        begin
            hold_done <= hold_asked;
            hold_left <= 80;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 13);
        end
    end

    // Every result request taken at this edge is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_result(out_kind, out_byte, out_last);
    end

    // Writes both limit registers, one per edge, and mirrors them in the tracker.
    task automatic set_limits(input logic [15:0] len, input logic [19:0] pend);
        cfg_we    <= 1'b1;
        cfg_index <= ldf_pkg::CFG_MAX_LINE_LENGTH;
        cfg_data  <= {4'd0, len};
        @(posedge clk);
        tracker.set_reg(ldf_pkg::CFG_MAX_LINE_LENGTH, {4'd0, len});
        cfg_index <= ldf_pkg::CFG_MAX_PENDING_BYTES;
        cfg_data  <= pend;
        @(posedge clk);
        tracker.set_reg(ldf_pkg::CFG_MAX_PENDING_BYTES, pend);
        cfg_we    <= 1'b0;
    endtask

    // Offers one byte request and waits until it is taken. With guarded set, a byte that
    // would make an overflow unavoidable is replaced by LF, so the block stays open.
    task automatic send_byte(input logic [7:0] b_in, input bit guarded);
        logic [7:0] b;
        b = b_in;
        if (guarded && tracker.must_break())
            b = ldf_pkg::BYTE_LF;
        if (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    // Waits for every owed result, then waits on so that a byte still in the front stage can finish.
    task automatic settle();
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Content bytes lean toward CR so that held and doubled CRs come up often.
    function automatic logic [7:0] pick_content();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return ldf_pkg::BYTE_CR;
        if (r < 13)
            return ldf_pkg::BYTE_LF;
        return 8'($urandom_range(255));
    endfunction

    // One line: mostly short, now and then long, ended by CR LF, by LF, or not at all.
    task automatic send_line();
        int n;
        int t;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        for (int k = 0; k < n; k++)
            send_byte(pick_content(), 1);
        t = $urandom_range(9);
        if (t < 5)
        begin
            send_byte(ldf_pkg::BYTE_CR, 1);
            send_byte(ldf_pkg::BYTE_LF, 1);
        end
        else if (t < 9)
        begin
            send_byte(ldf_pkg::BYTE_LF, 1);
        end
    endtask

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          phase_stop;
        logic [19:0] last_pend;
        logic [7:0]  b;

        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset limits: extreme byte values, an empty line, a lone
        // CR LF, two CRs in a row with the first one sent as data, and a CR before LF.
        send_byte(8'h41, 1);
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        send_byte(8'h7F, 1);
        send_byte(8'h80, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        send_byte(ldf_pkg::BYTE_CR, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        send_byte(ldf_pkg::BYTE_CR, 1);
        send_byte(ldf_pkg::BYTE_CR, 1);
        send_byte(8'h78, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        send_byte(8'h71, 1);
        send_byte(ldf_pkg::BYTE_CR, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        stop_input();
        settle();

        // A short cap truncates the line; the dropped bytes still count toward it.
        set_limits(16'd2, ldf_pkg::MAX_PENDING_BYTES_RST);
        send_byte(8'h61, 1);
        send_byte(8'h62, 1);
        send_byte(8'h63, 1);
        send_byte(8'h64, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        stop_input();
        settle();

        // With a zero cap nothing is kept, yet the line still ends with an end-of-line.
        set_limits(16'd0, ldf_pkg::MAX_PENDING_BYTES_RST);
        send_byte(8'h7A, 1);
        send_byte(8'h7A, 1);
        send_byte(ldf_pkg::BYTE_LF, 1);
        stop_input();
        settle();

        // Random phases. The first one starts with a long receiver hold-off while the
        // sender keeps offering, so the internal queue fills and in_stall must rise.
        // The fifth phase runs with no idling on either side.
        for (int p = 0; p < 7; p++)
        begin
            set_limits(phase_len[p], phase_pend[p]);
            calm = (p == 4);
            if (p == 0)
                hold_asked++;
            phase_stop = bytes_sent + 160;
            while (bytes_sent < phase_stop)
                send_line();
            // Close the line so a tighter pending limit in the next phase starts clean.
            send_byte(ldf_pkg::BYTE_LF, 1);
            stop_input();
            settle();
        end
        calm = 0;

        // Overflow: no LF arrives, so the pending limit is crossed, one error comes out
        // and every later byte is taken and ignored. Half the runs use a zero limit,
        // where the very first byte overflows.
        last_pend = ($urandom_range(1) == 0) ? 20'd0 : 20'($urandom_range(2, 40));
        set_limits(16'($urandom_range(1, 20)), last_pend);
        for (int k = 0; k < 60; k++)
        begin
            b = pick_content();
            if (b == ldf_pkg::BYTE_LF)
                b = ldf_pkg::BYTE_CR;
            send_byte(b, 0);
        end
        stop_input();

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
